/* rtl/sci_pkg.sv */
// -----------------------------------------------------------------------------
// sci_pkg: shared types and constants for the segment/circle intersection
// Fixed widths of the coordinate datapath, sideband structs of the pipeline
// and the configuration register codes.
// -----------------------------------------------------------------------------
package sci_pkg;

   // field widths
   localparam int COORD_W  = 24;            // Q15.8 coordinate
   localparam int RADIUS_W = COORD_W - 1;   // unsigned radius
   localparam int HIT_W    = 2;
   localparam int DELTA_W  = COORD_W + 1;   // end - start, start - center
   localparam int MAG_W    = COORD_W;       // magnitude of a delta
   localparam int PROD_W   = 2 * DELTA_W;   // product of two deltas
   localparam int RR_W     = 2 * RADIUS_W;
   localparam int A_W      = 2 * MAG_W + 1; // d.d
   localparam int B_W      = A_W + 1;       // d.p, signed
   localparam int LO_W     = 25;            // low split of a 49-bit operand
   localparam int HI_W     = A_W - LO_W;
   localparam int SQ_W     = 2 * A_W;       // b*b and A*|C|
   localparam int D_W      = SQ_W + 2;      // discriminant, signed
   localparam int RAD_W    = 4 * MAG_W;     // nonnegative discriminant bits
   localparam int ROOT_W   = RAD_W / 2;
   localparam int REM_W    = ROOT_W + 4;
   localparam int N_W      = B_W + 1;       // -b +/- root, signed
   localparam int NUM_W    = MAG_W + A_W;   // |d| * n
   localparam int Q_W      = MAG_W;         // quotient of one point offset
   localparam int LANES    = 4;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = Q_W;

   // stream beats
   localparam int REQ_W = 4 * COORD_W;
   localparam int RSP_RAW_W = HIT_W + 4 * COORD_W;
   localparam int RSP_W = ((RSP_RAW_W + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = COORD_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CENTER_X = 2'd0,
      CSR_CENTER_Y = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_sel_type;

   // segment geometry carried down the pipeline
   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [DELTA_W-1:0] dx;
      logic signed [DELTA_W-1:0] dy;
   } seg_type;

   // sideband through the square root chain
   typedef struct packed {
      seg_type               seg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
      logic                  no_hit;
      logic                  d_zero;
   } side_type;

   // square root cell state
   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [ROOT_W-1:0] root;
      logic [REM_W-1:0]  rem;
   } sqrt_type;

   // sideband through the divider chain
   typedef struct packed {
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic                      neg_x;
      logic                      neg_y;
      logic [A_W-1:0]            a;
      logic [HIT_W-1:0]          count;
   } tail_type;

   // divider lanes: first x, first y, second x, second y
   typedef struct packed {
      logic [LANES-1:0][A_W-1:0] rem;
      logic [LANES-1:0][Q_W-1:0] bits;
   } div_type;

endpackage

/* rtl/sci_front.sv */
// -----------------------------------------------------------------------------
// sci_front: quadratic coefficients and discriminant
// Seven register stages: deltas, products, A/b/C, magnitudes, split partial
// products, wide sums and the quarter discriminant D = b*b - A*C.
// -----------------------------------------------------------------------------
module sci_front import sci_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic signed [COORD_W-1:0] start_x,
   input  logic signed [COORD_W-1:0] start_y,
   input  logic signed [COORD_W-1:0] end_x,
   input  logic signed [COORD_W-1:0] end_y,
   input  logic signed [COORD_W-1:0] center_x,
   input  logic signed [COORD_W-1:0] center_y,
   input  logic [RADIUS_W-1:0]       radius,
   output logic                      out_valid,
   output side_type                  out_side,
   output logic [RAD_W-1:0]          out_rad
);

   typedef struct packed {
      seg_type                   seg;
      logic signed [DELTA_W-1:0] px;
      logic signed [DELTA_W-1:0] py;
   } s1_type;

   typedef struct packed {
      seg_type                  seg;
      logic signed [PROD_W-1:0] dxdx, dydy, dxpx, dypy, pxpx, pypy;
      logic [RR_W-1:0]          rr;
   } s2_type;

   typedef struct packed {
      seg_type               seg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
      logic signed [B_W-1:0] c;
   } s3_type;

   typedef struct packed {
      seg_type               seg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
      logic [A_W-1:0]        bm;
      logic [A_W-1:0]        cm;
      logic                  c_neg;
      logic                  a_zero;
   } s4_type;

   typedef struct packed {
      seg_type               seg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
      logic                  c_neg;
      logic                  a_zero;
      logic [2*LO_W-1:0]     bb_ll, ac_ll;
      logic [LO_W+HI_W-1:0]  bb_lh, ac_lh, ac_hl;
      logic [2*HI_W-1:0]     bb_hh, ac_hh;
   } s5_type;

   typedef struct packed {
      seg_type               seg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
      logic                  c_neg;
      logic                  a_zero;
      logic [SQ_W-1:0]       bb;
      logic [SQ_W-1:0]       ac;
   } s6_type;

   typedef struct packed {
      seg_type               seg;
      logic [A_W-1:0]        a;
      logic signed [B_W-1:0] b;
      logic                  a_zero;
      logic signed [D_W-1:0] d;
   } s7_type;

   logic [7:1] valid_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;

   logic signed [PROD_W:0] a_sum, b_sum, c_sum;
   logic signed [B_W-1:0]  b_neg, c_neg_val;
   logic [D_W-1:0]         ac_ext, ac_term;

   // stage 1: deltas
   always_comb begin
      s1_in.seg.sx = start_x;
      s1_in.seg.sy = start_y;
      s1_in.seg.dx = DELTA_W'(end_x) - DELTA_W'(start_x);
      s1_in.seg.dy = DELTA_W'(end_y) - DELTA_W'(start_y);
      s1_in.px     = DELTA_W'(start_x) - DELTA_W'(center_x);
      s1_in.py     = DELTA_W'(start_y) - DELTA_W'(center_y);
   end

   // stage 2: products
   always_comb begin
      s2_in.seg  = s1_ff.seg;
      s2_in.dxdx = s1_ff.seg.dx * s1_ff.seg.dx;
      s2_in.dydy = s1_ff.seg.dy * s1_ff.seg.dy;
      s2_in.dxpx = s1_ff.seg.dx * s1_ff.px;
      s2_in.dypy = s1_ff.seg.dy * s1_ff.py;
      s2_in.pxpx = s1_ff.px * s1_ff.px;
      s2_in.pypy = s1_ff.py * s1_ff.py;
      s2_in.rr   = RR_W'(radius) * RR_W'(radius);
   end

   // stage 3: A, b, C
   always_comb begin
      a_sum = (PROD_W+1)'(s2_ff.dxdx) + (PROD_W+1)'(s2_ff.dydy);
      b_sum = (PROD_W+1)'(s2_ff.dxpx) + (PROD_W+1)'(s2_ff.dypy);
      c_sum = (PROD_W+1)'(s2_ff.pxpx) + (PROD_W+1)'(s2_ff.pypy)
              - $signed({{(PROD_W+1-RR_W){1'b0}}, s2_ff.rr});
      s3_in.seg = s2_ff.seg;
      s3_in.a   = a_sum[A_W-1:0];
      s3_in.b   = b_sum[B_W-1:0];
      s3_in.c   = c_sum[B_W-1:0];
   end

   // stage 4: magnitudes of b and C
   always_comb begin
      b_neg     = -s3_ff.b;
      c_neg_val = -s3_ff.c;
      s4_in.seg    = s3_ff.seg;
      s4_in.a      = s3_ff.a;
      s4_in.b      = s3_ff.b;
      s4_in.bm     = s3_ff.b[B_W-1] ? b_neg[A_W-1:0] : s3_ff.b[A_W-1:0];
      s4_in.cm     = s3_ff.c[B_W-1] ? c_neg_val[A_W-1:0] : s3_ff.c[A_W-1:0];
      s4_in.c_neg  = s3_ff.c[B_W-1];
      s4_in.a_zero = (s3_ff.a == '0);
   end

   // stage 5: split partial products of b*b and A*|C|
   always_comb begin
      s5_in.seg    = s4_ff.seg;
      s5_in.a      = s4_ff.a;
      s5_in.b      = s4_ff.b;
      s5_in.c_neg  = s4_ff.c_neg;
      s5_in.a_zero = s4_ff.a_zero;
      s5_in.bb_ll  = (2*LO_W)'(s4_ff.bm[LO_W-1:0]) * (2*LO_W)'(s4_ff.bm[LO_W-1:0]);
      s5_in.bb_lh  = (LO_W+HI_W)'(s4_ff.bm[LO_W-1:0])
                     * (LO_W+HI_W)'(s4_ff.bm[A_W-1:LO_W]);
      s5_in.bb_hh  = (2*HI_W)'(s4_ff.bm[A_W-1:LO_W]) * (2*HI_W)'(s4_ff.bm[A_W-1:LO_W]);
      s5_in.ac_ll  = (2*LO_W)'(s4_ff.a[LO_W-1:0]) * (2*LO_W)'(s4_ff.cm[LO_W-1:0]);
      s5_in.ac_lh  = (LO_W+HI_W)'(s4_ff.a[LO_W-1:0])
                     * (LO_W+HI_W)'(s4_ff.cm[A_W-1:LO_W]);
      s5_in.ac_hl  = (LO_W+HI_W)'(s4_ff.a[A_W-1:LO_W])
                     * (LO_W+HI_W)'(s4_ff.cm[LO_W-1:0]);
      s5_in.ac_hh  = (2*HI_W)'(s4_ff.a[A_W-1:LO_W]) * (2*HI_W)'(s4_ff.cm[A_W-1:LO_W]);
   end

   // stage 6: recombine partial products
   always_comb begin
      s6_in.seg    = s5_ff.seg;
      s6_in.a      = s5_ff.a;
      s6_in.b      = s5_ff.b;
      s6_in.c_neg  = s5_ff.c_neg;
      s6_in.a_zero = s5_ff.a_zero;
      s6_in.bb = SQ_W'(s5_ff.bb_ll) + (SQ_W'(s5_ff.bb_lh) << (LO_W + 1))
                 + (SQ_W'(s5_ff.bb_hh) << (2 * LO_W));
      s6_in.ac = SQ_W'(s5_ff.ac_ll) + (SQ_W'(s5_ff.ac_lh) << LO_W)
                 + (SQ_W'(s5_ff.ac_hl) << LO_W) + (SQ_W'(s5_ff.ac_hh) << (2 * LO_W));
   end

   // stage 7: discriminant, A*|C| enters with the sign opposite to that of C
   always_comb begin
      ac_ext  = D_W'(s6_ff.ac);
      ac_term = s6_ff.c_neg ? ac_ext : (~ac_ext + D_W'(1));
      s7_in.seg    = s6_ff.seg;
      s7_in.a      = s6_ff.a;
      s7_in.b      = s6_ff.b;
      s7_in.a_zero = s6_ff.a_zero;
      s7_in.d      = $signed(D_W'(s6_ff.bb) + ac_term);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[6:1], in_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   // flags for the root stages
   always_comb begin
      out_valid       = valid_ff[7];
      out_side.seg    = s7_ff.seg;
      out_side.a      = s7_ff.a;
      out_side.b      = s7_ff.b;
      out_side.no_hit = s7_ff.a_zero | s7_ff.d[D_W-1];
      out_side.d_zero = (s7_ff.d == '0);
      out_rad         = s7_ff.d[RAD_W-1:0];
   end

endmodule

/* rtl/sci_sqrt_cell.sv */
// -----------------------------------------------------------------------------
// sci_sqrt_cell: one bit of the integer square root
// Brings down two radicand bits, tries root*4+1 against the remainder and
// hands the updated state to the next cell.
// -----------------------------------------------------------------------------
module sci_sqrt_cell import sci_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  side_type in_side,
   input  sqrt_type in_sq,
   output logic     out_valid,
   output side_type out_side,
   output sqrt_type out_sq
);

   logic             valid_ff;
   side_type         side_ff;
   sqrt_type         sq_ff, sq_in;
   logic [REM_W-1:0] rem_sh, trial;
   logic             take;

   // try one root bit
   always_comb begin
      rem_sh = {in_sq.rem[REM_W-3:0], in_sq.rad[RAD_W-1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, in_sq.root, 2'b01};
      take   = (rem_sh >= trial);
      sq_in.rem  = take ? (rem_sh - trial) : rem_sh;
      sq_in.root = {in_sq.root[ROOT_W-2:0], take};
      sq_in.rad  = {in_sq.rad[RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         sq_ff   <= sq_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_sq    = sq_ff;

endmodule

/* rtl/sci_div_cell.sv */
// -----------------------------------------------------------------------------
// sci_div_cell: one quotient bit of the four point dividers
// Each lane shifts one numerator bit into its remainder, subtracts A when
// it fits and shifts the quotient bit in at the bottom.
// -----------------------------------------------------------------------------
module sci_div_cell import sci_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_valid,
   input  tail_type in_tail,
   input  div_type  in_div,
   output logic     out_valid,
   output tail_type out_tail,
   output div_type  out_div
);

   logic           valid_ff;
   tail_type       tail_ff;
   div_type        div_ff, div_in;
   logic [A_W:0]   rem_sh [LANES];
   logic [A_W:0]   rem_sub [LANES];
   logic [LANES-1:0] take;

   // restoring step per lane
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rem_sh[i]  = {in_div.rem[i], in_div.bits[i][Q_W-1]};
         rem_sub[i] = rem_sh[i] - {1'b0, in_tail.a};
         take[i]    = (rem_sh[i] >= {1'b0, in_tail.a});
         div_in.rem[i]  = take[i] ? rem_sub[i][A_W-1:0] : rem_sh[i][A_W-1:0];
         div_in.bits[i] = {in_div.bits[i][Q_W-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tail_ff <= in_tail;
         div_ff  <= div_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_tail  = tail_ff;
   assign out_div   = div_ff;

endmodule

/* rtl/segment_circle_intersection_top.sv */
// -----------------------------------------------------------------------------
// segment_circle_intersection_top: segment against circle intersection
// Solves the segment quadratic in fixed point and returns the hit count and
// up to two points on the segment for every segment beat.
// -----------------------------------------------------------------------------
// Throughput: one segment per cycle while no finished result is held by a
// stalled rsp side; 7 coefficient stages, 48 square root cells,
// 3 root/numerator stages, 24 divider cells and the output register.
// A stalled rsp side holds the pipeline only once a result reaches its end.
// Reset clears all valid bits and sets center and radius to zero.
// -----------------------------------------------------------------------------
module segment_circle_intersection_top import sci_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // start_x, start_y, end_x, end_y
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // hit_count, first_x, first_y,
                                              // second_x, second_y, zero pad
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef struct packed {
      tail_type         tail;
      logic [MAG_W-1:0] mx;
      logic [MAG_W-1:0] my;
      logic [A_W-1:0]   nf;
      logic [A_W-1:0]   ns;
   } r1_type;

   typedef struct packed {
      tail_type                          tail;
      logic [LANES-1:0][LO_W+MAG_W-1:0]  lo;
      logic [LANES-1:0][HI_W+MAG_W-1:0]  hi;
   } r2_type;

   // configuration
   logic signed [COORD_W-1:0] center_x_ff, center_y_ff;
   logic [RADIUS_W-1:0]       radius_ff;

   // pipeline control
   logic adv, load_out;

   // coefficient front end
   logic       fr_valid;
   side_type   fr_side;
   logic [RAD_W-1:0] fr_rad;

   // square root chain
   logic     sq_valid [SQRT_STEPS+1];
   side_type sq_side  [SQRT_STEPS+1];
   sqrt_type sq_data  [SQRT_STEPS+1];

   // root selection and numerators
   side_type               ss;
   logic signed [N_W-1:0]  nb, root_ext, a_ext, n1, n2;
   logic                   k1, k2;
   logic signed [DELTA_W-1:0] dx_neg, dy_neg;
   logic                   r1_valid_ff, r2_valid_ff;
   r1_type                 r1_ff, r1_in;
   r2_type                 r2_ff, r2_in;
   logic [MAG_W-1:0]       lane_mag [LANES];
   logic [A_W-1:0]         lane_n   [LANES];
   logic [NUM_W-1:0]       num      [LANES];

   // divider chain
   logic     dv_valid [DIV_STEPS+1];
   tail_type dv_tail  [DIV_STEPS+1];
   div_type  dv_data  [DIV_STEPS+1];
   logic     dv0_valid_ff;
   tail_type dv0_tail_ff;
   div_type  dv0_data_ff, dv0_data_in;

   // output register
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]    rsp_tdata_ff, rsp_tdata_in;
   tail_type            tl;
   logic [COORD_W-1:0]  fx, fy, px2, py2;

   // write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         radius_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_sel_type'(csr_index))
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end
   end

   // advance unless a finished beat would be dropped
   assign load_out   = !rsp_tvalid_ff || rsp_tready;
   assign adv        = load_out || !dv_valid[DIV_STEPS];
   assign req_tready = adv;

   sci_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid),
      .start_x   (req_tdata[COORD_W-1:0]),
      .start_y   (req_tdata[2*COORD_W-1:COORD_W]),
      .end_x     (req_tdata[3*COORD_W-1:2*COORD_W]),
      .end_y     (req_tdata[4*COORD_W-1:3*COORD_W]),
      .center_x  (center_x_ff),
      .center_y  (center_y_ff),
      .radius    (radius_ff),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_rad   (fr_rad)
   );

   // feed the root chain
   always_comb begin
      sq_valid[0]     = fr_valid;
      sq_side[0]      = fr_side;
      sq_data[0].rad  = fr_rad;
      sq_data[0].root = '0;
      sq_data[0].rem  = '0;
   end

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      sci_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (sq_valid[g]),
         .in_side   (sq_side[g]),
         .in_sq     (sq_data[g]),
         .out_valid (sq_valid[g+1]),
         .out_side  (sq_side[g+1]),
         .out_sq    (sq_data[g+1])
      );
   end

   // pick the roots on the segment
   always_comb begin
      ss       = sq_side[SQRT_STEPS];
      nb       = -$signed({ss.b[B_W-1], ss.b});
      root_ext = $signed(N_W'(sq_data[SQRT_STEPS].root));
      a_ext    = $signed(N_W'(ss.a));
      n1       = nb + root_ext;
      n2       = nb - root_ext;
      k1       = !n1[N_W-1] && (n1 <= a_ext);
      k2       = !n2[N_W-1] && (n2 <= a_ext);
      dx_neg   = -ss.seg.dx;
      dy_neg   = -ss.seg.dy;

      r1_in.tail.sx    = ss.seg.sx;
      r1_in.tail.sy    = ss.seg.sy;
      r1_in.tail.neg_x = ss.seg.dx[DELTA_W-1];
      r1_in.tail.neg_y = ss.seg.dy[DELTA_W-1];
      r1_in.tail.a     = ss.a;
      if (ss.no_hit) begin
         r1_in.tail.count = '0;
      end else if (ss.d_zero) begin
         r1_in.tail.count = HIT_W'(k1);
      end else begin
         r1_in.tail.count = HIT_W'(k1) + HIT_W'(k2);
      end
      r1_in.mx = ss.seg.dx[DELTA_W-1] ? dx_neg[MAG_W-1:0] : ss.seg.dx[MAG_W-1:0];
      r1_in.my = ss.seg.dy[DELTA_W-1] ? dy_neg[MAG_W-1:0] : ss.seg.dy[MAG_W-1:0];
      r1_in.nf = k1 ? n1[A_W-1:0] : n2[A_W-1:0];
      r1_in.ns = n2[A_W-1:0];
   end

   // split products |d| * n per lane
   always_comb begin
      lane_mag[0] = r1_ff.mx;
      lane_mag[1] = r1_ff.my;
      lane_mag[2] = r1_ff.mx;
      lane_mag[3] = r1_ff.my;
      lane_n[0]   = r1_ff.nf;
      lane_n[1]   = r1_ff.nf;
      lane_n[2]   = r1_ff.ns;
      lane_n[3]   = r1_ff.ns;
      r2_in.tail  = r1_ff.tail;
      for (int i = 0; i < LANES; i++) begin
         r2_in.lo[i] = (LO_W+MAG_W)'(lane_mag[i]) * (LO_W+MAG_W)'(lane_n[i][LO_W-1:0]);
         r2_in.hi[i] = (HI_W+MAG_W)'(lane_mag[i]) * (HI_W+MAG_W)'(lane_n[i][A_W-1:LO_W]);
      end
   end

   // numerators and divider entry
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         num[i] = NUM_W'(r2_ff.lo[i]) + (NUM_W'(r2_ff.hi[i]) << LO_W);
         dv0_data_in.rem[i]  = num[i][NUM_W-1:Q_W];
         dv0_data_in.bits[i] = num[i][Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff  <= 1'b0;
         r2_valid_ff  <= 1'b0;
         dv0_valid_ff <= 1'b0;
      end else if (adv) begin
         r1_valid_ff  <= sq_valid[SQRT_STEPS];
         r2_valid_ff  <= r1_valid_ff;
         dv0_valid_ff <= r2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff       <= r1_in;
         r2_ff       <= r2_in;
         dv0_tail_ff <= r2_ff.tail;
         dv0_data_ff <= dv0_data_in;
      end
   end

   assign dv_valid[0] = dv0_valid_ff;
   assign dv_tail[0]  = dv0_tail_ff;
   assign dv_data[0]  = dv0_data_ff;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
      sci_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (adv),
         .in_valid  (dv_valid[g]),
         .in_tail   (dv_tail[g]),
         .in_div    (dv_data[g]),
         .out_valid (dv_valid[g+1]),
         .out_tail  (dv_tail[g+1]),
         .out_div   (dv_data[g+1])
      );
   end

   // form the points and pack the beat
   always_comb begin
      tl  = dv_tail[DIV_STEPS];
      fx  = tl.neg_x ? (tl.sx - dv_data[DIV_STEPS].bits[0])
                     : (tl.sx + dv_data[DIV_STEPS].bits[0]);
      fy  = tl.neg_y ? (tl.sy - dv_data[DIV_STEPS].bits[1])
                     : (tl.sy + dv_data[DIV_STEPS].bits[1]);
      px2 = tl.neg_x ? (tl.sx - dv_data[DIV_STEPS].bits[2])
                     : (tl.sx + dv_data[DIV_STEPS].bits[2]);
      py2 = tl.neg_y ? (tl.sy - dv_data[DIV_STEPS].bits[3])
                     : (tl.sy + dv_data[DIV_STEPS].bits[3]);
      if (tl.count == '0) begin
         fx = '0;
         fy = '0;
      end
      if (tl.count != HIT_W'(2)) begin
         px2 = '0;
         py2 = '0;
      end
      rsp_tdata_in  = RSP_W'({py2, px2, fy, fx, tl.count});
      rsp_tvalid_in = load_out ? dv_valid[DIV_STEPS] : rsp_tvalid_ff;
   end

   // hold the result beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

/* tb/segment_circle_intersection_top_tb.sv */
// -----------------------------------------------------------------------------
// segment_circle_intersection_top_tb: self-checking bench for the segment and
// circle intersection block
// Streams segments through the block under several circle settings and
// handshake idle patterns. Each result is checked against an exact wide
// integer prediction of the hit count and the truncated hit points.
// -----------------------------------------------------------------------------
module segment_circle_intersection_top_tb;
   import sci_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 100;

   typedef logic signed [159:0] wide_t;

   typedef struct packed {
      logic [COORD_W-1:0] second_y;
      logic [COORD_W-1:0] second_x;
      logic [COORD_W-1:0] first_y;
      logic [COORD_W-1:0] first_x;
      logic [HIT_W-1:0]   hit_count;
   } hit_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_CENTER_X;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // circle copy kept by the bench
   logic signed [COORD_W-1:0] circ_cx = '0;
   logic signed [COORD_W-1:0] circ_cy = '0;
   logic [RADIUS_W-1:0]       circ_r  = '0;

   logic [REQ_W-1:0] seg_queue[$];
   hit_type          hit_queue[$];
   bit               drive_en = 1'b0;
   bit               req_fire = 1'b0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               errors = 0;
   int               stuck = 0;
   int               seg_count = 0;
   int               hit_seen[3] = '{0, 0, 0};

   segment_circle_intersection_top u_top (.*);

   always #5 clock = ~clock;

   // exact intersection of one segment with the current circle
   function automatic hit_type intersect_segment(logic [REQ_W-1:0] seg);
      longint sx, sy, ex, ey, dx, dy, px, py;
      wide_t  a, b, c, d, s, cand, n1, n2, one;
      wide_t  nk[2];
      int     kept;
      hit_type h;
      sx = longint'($signed(seg[0*COORD_W +: COORD_W]));
      sy = longint'($signed(seg[1*COORD_W +: COORD_W]));
      ex = longint'($signed(seg[2*COORD_W +: COORD_W]));
      ey = longint'($signed(seg[3*COORD_W +: COORD_W]));
      dx = ex - sx;
      dy = ey - sy;
      px = sx - longint'(circ_cx);
      py = sy - longint'(circ_cy);
      h = '0;
      one = 1;
      a = wide_t'(dx) * wide_t'(dx) + wide_t'(dy) * wide_t'(dy);
      b = wide_t'(dx) * wide_t'(px) + wide_t'(dy) * wide_t'(py);
      c = wide_t'(px) * wide_t'(px) + wide_t'(py) * wide_t'(py)
          - wide_t'({1'b0, circ_r}) * wide_t'({1'b0, circ_r});
      if (a == 0) return h;
      d = b * b - a * c;
      if (d < 0) return h;
      kept = 0;
      if (d == 0) begin
         n1 = -b;
         if (n1 >= 0 && n1 <= a) begin
            nk[kept] = n1;
            kept++;
         end
      end else begin
         // floor square root, one bit at a time
         s = 0;
         for (int k = 63; k >= 0; k--) begin
            cand = s | (one << k);
            if (cand * cand <= d) s = cand;
         end
         n1 = -b + s;
         n2 = -b - s;
         if (n1 >= 0 && n1 <= a) begin
            nk[kept] = n1;
            kept++;
         end
         if (n2 >= 0 && n2 <= a) begin
            nk[kept] = n2;
            kept++;
         end
      end
      h.hit_count = kept[HIT_W-1:0];
      if (kept > 0) begin
         h.first_x = COORD_W'(sx + longint'((wide_t'(dx) * nk[0]) / a));
         h.first_y = COORD_W'(sy + longint'((wide_t'(dy) * nk[0]) / a));
      end
      if (kept > 1) begin
         h.second_x = COORD_W'(sx + longint'((wide_t'(dx) * nk[1]) / a));
         h.second_y = COORD_W'(sy + longint'((wide_t'(dy) * nk[1]) / a));
      end
      return h;
   endfunction

   function automatic logic [REQ_W-1:0] pack_seg(longint sx, longint sy,
                                                 longint ex, longint ey);
      return {COORD_W'(ey), COORD_W'(ex), COORD_W'(sy), COORD_W'(sx)};
   endfunction

   // coordinate within span of c, clamped to the field range
   function automatic longint near_coord(longint c, longint span);
      longint v;
      v = c + longint'($urandom_range(32'(2 * span))) - span;
      if (v > 8388607) v = 8388607;
      if (v < -8388608) v = -8388608;
      return v;
   endfunction

   function automatic logic [REQ_W-1:0] random_seg();
      longint span, sx, sy;
      int     pick;
      pick = $urandom_range(9);
      span = 2 * longint'(circ_r) + $urandom_range(64) + 1;
      if ($urandom_range(3) == 0) span = $urandom_range(300) + 1;
      sx = near_coord(circ_cx, span);
      sy = near_coord(circ_cy, span);
      if (pick < 2)
         return {$urandom, $urandom, $urandom};
      else if (pick == 9) begin
         // degenerate or axis aligned
         case ($urandom_range(2))
            0: return pack_seg(sx, sy, sx, sy);
            1: return pack_seg(sx, sy, near_coord(circ_cx, span), sy);
            default: return pack_seg(sx, sy, sx, near_coord(circ_cy, span));
         endcase
      end
      return pack_seg(sx, sy, near_coord(circ_cx, span), near_coord(circ_cy, span));
   endfunction

   task automatic write_csr(csr_sel_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_CENTER_X: circ_cx = value;
         CSR_CENTER_Y: circ_cy = value;
         CSR_RADIUS:   circ_r  = value[RADIUS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // hold the sender until every expected beat is back
   task automatic drain();
      while (seg_queue.size() != 0 || req_tvalid || hit_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
         default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
   endtask

   task automatic run_phase(logic [23:0] cx, logic [23:0] cy, logic [23:0] r,
                            int count, int mode);
      drain();
      write_csr(CSR_CENTER_X, cx);
      write_csr(CSR_CENTER_Y, cy);
      write_csr(CSR_RADIUS, r);
      set_idling(mode);
      repeat (count) seg_queue.push_back(random_seg());
   endtask

   // driver: present segment beats on the falling edge
   always @(negedge clock) begin
      if (drive_en) begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         if (!req_tvalid || req_fire) begin
            if (seg_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= seg_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on accepted segments, check accepted results
   always @(posedge clock) begin
      hit_type got, want;
      req_fire = req_tvalid && req_tready && !reset;
      if (req_fire) begin
         hit_queue.push_back(intersect_segment(req_tdata));
         seg_count++;
      end
      if (rsp_tvalid && rsp_tready && !reset) begin
         got = hit_type'(rsp_tdata[RSP_RAW_W-1:0]);
         if (hit_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %h", got);
         end else begin
            want = hit_queue.pop_front();
            if (want.hit_count < 3) hit_seen[want.hit_count]++;
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: count %0d/%0d p1 %h,%h/%h,%h p2 %h,%h/%h,%h",
                           want.hit_count, got.hit_count,
                           want.first_x, want.first_y, got.first_x, got.first_y,
                           want.second_x, want.second_y, got.second_x, got.second_y);
            end
         end
      end
      // watchdog on outstanding work with no beat moving
      if (req_fire || (rsp_tvalid && rsp_tready)
          || (seg_queue.size() == 0 && hit_queue.size() == 0))
         stuck = 0;
      else
         stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      drive_en = 1'b1;

      // zero radius at origin: a chord through the center touches one point
      seg_queue.push_back(pack_seg(-100, 0, 100, 0));
      seg_queue.push_back(pack_seg(0, 0, 0, 0));
      seg_queue.push_back(pack_seg(-100, 5, 100, 5));
      drain();

      // directed cases against a radius of 10.0
      write_csr(CSR_RADIUS, 24'd2560);
      seg_queue.push_back(pack_seg(100, 100, 100, 100));          // zero length
      seg_queue.push_back(pack_seg(-5000, 2560, 5000, 2560));     // tangent
      seg_queue.push_back(pack_seg(5000, -2560, -5000, -2560));   // tangent
      seg_queue.push_back(pack_seg(-5000, 0, 5000, 0));           // two hits
      seg_queue.push_back(pack_seg(0, 3000, 0, -3000));           // two hits
      seg_queue.push_back(pack_seg(0, 0, 5000, 0));               // start inside
      seg_queue.push_back(pack_seg(5000, 1000, 0, 0));            // end inside
      seg_queue.push_back(pack_seg(-5000, 9000, 5000, 9000));     // clear miss
      seg_queue.push_back(pack_seg(0, 0, 10, 10));                // fully inside
      seg_queue.push_back(pack_seg(2560, 0, 6000, 0));            // touches at start
      seg_queue.push_back(pack_seg(3000, 0, 6000, 0));            // roots off segment
      seg_queue.push_back(pack_seg(-8388608, -8388608, 8388607, 8388607));
      seg_queue.push_back(pack_seg(8388607, -8388608, -8388608, 8388607));
      seg_queue.push_back(pack_seg(-8388608, -8388608, -8388608, -8388608));
      seg_queue.push_back(pack_seg(8388607, 8388607, -8388608, 8388607));
      drain();

      // extreme circles, then assorted random ones
      run_phase(24'h800000, 24'h7fffff, 24'h7fffff, 170, 0);
      run_phase(24'h7fffff, 24'h800000, 24'h000000, 170, 1);
      run_phase(24'h000000, 24'h000000, 24'h7fffff, 170, 2);
      run_phase(24'h800000, 24'h800000, 24'h000400, 170, 3);
      for (int p = 0; p < 4; p++)
         run_phase(24'($urandom), 24'($urandom), 24'($urandom_range(20000)),
                   170, p);
      drain();

      $display("checked %0d segments: %0d misses, %0d single hits, %0d double hits",
               seg_count, hit_seen[0], hit_seen[1], hit_seen[2]);
      $display("circle settings covered extreme centers, zero and full radius");
      if (errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/sci_pkg.sv
rtl/sci_front.sv
rtl/sci_sqrt_cell.sv
rtl/sci_div_cell.sv
rtl/segment_circle_intersection_top.sv
tb/segment_circle_intersection_top_tb.sv
